// ----- hw/rtl/sacl_pkg.sv -----
// Shared types and constants for the set-associative cache tag controller.
package sacl_pkg;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int CFG_W     = 4;
    localparam int WAY_OUT_W = 3;
    localparam int SET_OUT_W = 10;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_LRU_MODE  = 3'd0,
        REG_WB_ALLOC  = 3'd1,
        REG_BLOCK_LOG = 3'd2,
        REG_SET_LOG   = 3'd3,
        REG_WAYS      = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic             lru_mode;
        logic             write_back_allocate;
        logic [CFG_W-1:0] block_size_log2;
        logic [CFG_W-1:0] set_count_log2;
        logic [CFG_W-1:0] ways_in_use;
    } cfg_t;

    typedef struct packed {
        logic clear_wr;
        logic lookup;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } sts_t;

endpackage

// ----- hw/rtl/sacl_ctrl.sv -----
// Sequencer for the tag controller: RAM clearing pass, lookup and update.
module sacl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  sacl_pkg::sts_t sts,
    output sacl_pkg::cmd_t cmd,
    output logic          in_stall
);
    import sacl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!sts.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.lookup = in_valid;
            end
            ST_UPDATE:
            begin
                cmd.update = !sts.out_blocked;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- hw/rtl/sacl_dp.sv -----
// Tag RAM, hit and victim logic, rank update and result register.
module sacl_dp #(
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 1024,
    parameter int RANK_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sacl_pkg::cfg_t            cfg,
    input  sacl_pkg::cmd_t            cmd,
    output sacl_pkg::sts_t            sts,
    input  logic                      kind,
    input  logic [sacl_pkg::ADDR_W-1:0] address,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0] way,
    output logic                      allocated,
    output logic                      dirty_eviction,
    output logic [sacl_pkg::TAG_W-1:0] victim_tag,
    output logic [sacl_pkg::SET_OUT_W-1:0] set_index
);
    import sacl_pkg::*;

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_LIM = $clog2(MAX_SETS + 1) - 1;
    localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

    typedef logic [MAX_WAYS-1:0]                valid_row_t;
    typedef logic [MAX_WAYS-1:0][TAG_W-1:0]     tag_row_t;
    typedef logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank_row_t;

    valid_row_t mem_valid [MAX_SETS];
    valid_row_t mem_dirty [MAX_SETS];
    tag_row_t   mem_tag   [MAX_SETS];
    rank_row_t  mem_rank  [MAX_SETS];

    valid_row_t rd_valid_reg;
    valid_row_t rd_dirty_reg;
    tag_row_t   rd_tag_reg;
    rank_row_t  rd_rank_reg;

    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             kind_reg;

    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [WAY_OUT_W-1:0]      way_reg;
    logic                      alloc_reg;
    logic                      dev_reg;
    logic [TAG_W-1:0]          vtag_reg;
    logic [SET_OUT_W-1:0]      set_out_reg;

    logic [CFG_W-1:0]  set_bits;
    logic [4:0]        n_ways;
    logic [ADDR_W-1:0] shifted;
    logic [ADDR_W-1:0] set_mask;
    logic [SET_W-1:0]  set_in;
    logic [TAG_W-1:0]  tag_in;

    logic [MAX_WAYS-1:0] in_use;
    logic                hit_c;
    logic [WAY_W-1:0]    hit_way;
    logic                any_inv;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    vic_way;
    logic [RANK_BITS-1:0] vic_rank;
    logic [WAY_W-1:0]    sel_way;
    logic                do_alloc;
    logic                touch;
    logic [RANK_BITS-1:0] sel_rank;
    valid_row_t          new_valid;
    valid_row_t          new_dirty;
    tag_row_t            new_tag;
    rank_row_t           new_rank;
    logic                dev_c;

    function automatic logic [RANK_BITS-1:0] sat_inc(input logic [RANK_BITS-1:0] r);
        sat_inc = (r == RANK_MAX) ? r : r + 1'b1;
    endfunction

    // Address split for the incoming item.
    always_comb
    begin
        set_bits = (int'(cfg.set_count_log2) > SET_LIM) ? CFG_W'(SET_LIM)
                                                        : cfg.set_count_log2;
        shifted  = address >> cfg.block_size_log2;
        set_mask = (ADDR_W'(1) << set_bits) - 1'b1;
        set_in   = SET_W'(shifted & set_mask);
        tag_in   = address >> (5'(cfg.block_size_log2) + 5'(set_bits));
    end

    always_comb
    begin
        if (cfg.ways_in_use == '0)
        begin
            n_ways = 5'd1;
        end
        else if (int'(cfg.ways_in_use) > MAX_WAYS)
        begin
            n_ways = 5'(MAX_WAYS);
        end
        else
        begin
            n_ways = 5'(cfg.ways_in_use);
        end
    end

    // Hit search, first free way and victim choice over the row read back.
    always_comb
    begin
        hit_c    = 1'b0;
        hit_way  = '0;
        any_inv  = 1'b0;
        inv_way  = '0;
        vic_way  = '0;
        vic_rank = rd_rank_reg[0];
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            in_use[i] = (i < int'(n_ways));
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (in_use[i] && rd_valid_reg[i] && rd_tag_reg[i] == tag_reg)
            begin
                hit_c   = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (in_use[i] && !rd_valid_reg[i])
            begin
                any_inv = 1'b1;
                inv_way = WAY_W'(i);
            end
        end
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if (in_use[i])
            begin
                if (cfg.lru_mode ? (rd_rank_reg[i] > vic_rank)
                                 : (rd_rank_reg[i] < vic_rank))
                begin
                    vic_way  = WAY_W'(i);
                    vic_rank = rd_rank_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        do_alloc = !hit_c && !(kind_reg && !cfg.write_back_allocate);
        touch    = hit_c || do_alloc;
        if (hit_c)
        begin
            sel_way = hit_way;
        end
        else if (any_inv)
        begin
            sel_way = inv_way;
        end
        else
        begin
            sel_way = vic_way;
        end
        sel_rank  = rd_rank_reg[sel_way];
        dev_c     = do_alloc && !any_inv && rd_dirty_reg[sel_way];
        new_valid = rd_valid_reg;
        new_dirty = rd_dirty_reg;
        new_tag   = rd_tag_reg;
        new_rank  = rd_rank_reg;
        if (touch)
        begin
            if (cfg.lru_mode)
            begin
                for (int i = 0; i < MAX_WAYS; i++)
                begin
                    if (in_use[i])
                    begin
                        if (!rd_valid_reg[sel_way] || rd_rank_reg[i] < sel_rank)
                        begin
                            new_rank[i] = sat_inc(rd_rank_reg[i]);
                        end
                    end
                end
                new_rank[sel_way] = '0;
            end
            else
            begin
                new_rank[sel_way] = sat_inc(sel_rank);
            end
        end
        if (hit_c && kind_reg && cfg.write_back_allocate)
        begin
            new_dirty[sel_way] = 1'b1;
        end
        if (do_alloc)
        begin
            new_valid[sel_way] = 1'b1;
            new_dirty[sel_way] = kind_reg;
            new_tag[sel_way]   = tag_reg;
        end
    end

    // Tag RAM: one write port shared by the clearing pass and updates.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem_valid[clr_cnt_reg] <= '0;
            mem_dirty[clr_cnt_reg] <= '0;
            mem_tag[clr_cnt_reg]   <= '0;
            mem_rank[clr_cnt_reg]  <= '0;
        end
        else if (cmd.update)
        begin
            mem_valid[set_reg] <= new_valid;
            mem_dirty[set_reg] <= new_dirty;
            mem_tag[set_reg]   <= new_tag;
            mem_rank[set_reg]  <= new_rank;
        end
        if (cmd.lookup)
        begin
            rd_valid_reg <= mem_valid[set_in];
            rd_dirty_reg <= mem_dirty[set_in];
            rd_tag_reg   <= mem_tag[set_in];
            rd_rank_reg  <= mem_rank[set_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            set_reg  <= set_in;
            tag_reg  <= tag_in;
            kind_reg <= kind;
        end
        if (cmd.update)
        begin
            hit_reg     <= hit_c;
            way_reg     <= touch ? WAY_OUT_W'(sel_way) : '0;
            alloc_reg   <= do_alloc;
            dev_reg     <= dev_c;
            vtag_reg    <= dev_c ? rd_tag_reg[sel_way] : '0;
            set_out_reg <= SET_OUT_W'(set_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clear_last  = (clr_cnt_reg == SET_W'(MAX_SETS - 1));
    assign sts.out_blocked = out_valid_reg && out_stall;

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign way            = way_reg;
    assign allocated      = alloc_reg;
    assign dirty_eviction = dev_reg;
    assign victim_tag     = vtag_reg;
    assign set_index      = set_out_reg;

endmodule

// ----- hw/rtl/set_assoc_cache_lru_lfu.sv -----
// Top level of the set-associative cache tag controller with its register port.
// Each accepted item passes a lookup state, which reads the addressed set's
// row (valid, dirty, tag and rank of every way) from the tag RAM, and then an
// update state, which resolves hit, victim and rank changes, writes the row
// back and loads the result register. The next item is taken only once that
// update is done, so no new item is accepted while one is in work; a result
// that is still waiting holds the following item in its update cycle. After
// reset a clearing pass zeroes the tag RAM, one set per cycle, and no item is
// accepted until it ends. Registers at byte offsets 0x0 to 0x10: LRU mode,
// write-back allocate, block size log2, set count log2 and ways in use; write
// them only while no item is in flight.
module set_assoc_cache_lru_lfu #(
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 1024,
    parameter int RANK_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0]    paddr,
    input  logic [sacl_pkg::PDATA_W-1:0]    pwdata,
    output logic [sacl_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [sacl_pkg::ADDR_W-1:0]     address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]  way,
    output logic                            allocated,
    output logic                            dirty_eviction,
    output logic [sacl_pkg::TAG_W-1:0]      victim_tag,
    output logic [sacl_pkg::SET_OUT_W-1:0]  set_index
);
    import sacl_pkg::*;

    cfg_t     cfg_reg;
    cmd_t     cmd;
    sts_t     sts;
    reg_idx_t reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lru_mode            <= 1'b1;
            cfg_reg.write_back_allocate <= 1'b1;
            cfg_reg.block_size_log2     <= CFG_W'(5);
            cfg_reg.set_count_log2      <= CFG_W'(10);
            cfg_reg.ways_in_use         <= CFG_W'(8);
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_LRU_MODE:  cfg_reg.lru_mode            <= pwdata[0];
                REG_WB_ALLOC:  cfg_reg.write_back_allocate <= pwdata[0];
                REG_BLOCK_LOG: cfg_reg.block_size_log2     <= pwdata[CFG_W-1:0];
                REG_SET_LOG:   cfg_reg.set_count_log2      <= pwdata[CFG_W-1:0];
                REG_WAYS:      cfg_reg.ways_in_use         <= pwdata[CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_LRU_MODE:  prdata = PDATA_W'(cfg_reg.lru_mode);
            REG_WB_ALLOC:  prdata = PDATA_W'(cfg_reg.write_back_allocate);
            REG_BLOCK_LOG: prdata = PDATA_W'(cfg_reg.block_size_log2);
            REG_SET_LOG:   prdata = PDATA_W'(cfg_reg.set_count_log2);
            REG_WAYS:      prdata = PDATA_W'(cfg_reg.ways_in_use);
            default:       prdata = '0;
        endcase
    end

    sacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    sacl_dp #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .RANK_BITS (RANK_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .way            (way),
        .allocated      (allocated),
        .dirty_eviction (dirty_eviction),
        .victim_tag     (victim_tag),
        .set_index      (set_index)
    );

endmodule

// ----- hw/rtl/sacl_checker.sv -----
// Port-level assertions for the cache tag controller and their binding.
module sacl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            hit,
    input logic [sacl_pkg::WAY_OUT_W-1:0]  way,
    input logic                            allocated,
    input logic                            dirty_eviction,
    input logic [sacl_pkg::TAG_W-1:0]      victim_tag
);
    import sacl_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(way)
            && $stable(victim_tag))
        else $error("stalled result changed");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while another was in work");

    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && allocated))
        else $error("hit and fill reported together");

    a_evict_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !allocated |-> !dirty_eviction && victim_tag == '0)
        else $error("eviction reported without a fill");

    a_way_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit && !allocated |-> way == '0)
        else $error("way set on an access that touched no line");

endmodule

bind set_assoc_cache_lru_lfu sacl_checker u_sacl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .way            (way),
    .allocated      (allocated),
    .dirty_eviction (dirty_eviction),
    .victim_tag     (victim_tag)
);
